>>> rtl/lcs_pkg.sv
// lcs_pkg: shared sizes, action codes and the search token for the LCS threshold block.
// Used by lcs_cell and lcs_threshold_update; depends on nothing else.
package lcs_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int COLUMN_BITS = 16;

	// fixed port width of the column field
	localparam int COL_PORT_W = 16;
	// entry count and search position span 0..TABLE_DEPTH
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int SLOT_W = $clog2(TABLE_DEPTH);
	// one search level per address bit, plus one for the last entry
	localparam int NLVL = $clog2(TABLE_DEPTH) + 1;

	typedef enum logic [1:0] {
		ACT_KEEP    = 2'd0,
		ACT_REPLACE = 2'd1,
		ACT_APPEND  = 2'd2,
		ACT_DROP    = 2'd3
	} action_t;

	typedef struct packed {
		logic                   valid;
		logic                   fin;
		logic                   eq;
		logic [COLUMN_BITS-1:0] key;
		logic [CNT_W-1:0]       pos;
	} token_t;

endpackage

>>> rtl/lcs_ram.sv
// lcs_ram: generic simple RAM, one write port and two registered read ports.
// Holds the table entries of one search level; no package dependency.
module lcs_ram #(
	parameter int DEPTH = 2,
	parameter int AW    = 1,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr0,
	input  logic [AW-1:0] raddr1,
	output logic [DW-1:0] rdata0,
	output logic [DW-1:0] rdata1
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata0_q;
	logic [DW-1:0] rdata1_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0_q <= mem[raddr0];
		rdata1_q <= mem[raddr1];
	end

	assign rdata0 = rdata0_q;
	assign rdata1 = rdata1_q;

endmodule

>>> rtl/lcs_cell.sv
// lcs_cell: one level of the threshold search; compares the key with the entry
// fetched for its level and hands the token to the next level. Uses lcs_pkg.
module lcs_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [lcs_pkg::CNT_W-1:0] step,
	input  logic [lcs_pkg::CNT_W-1:0] count,
	input  lcs_pkg::token_t           tok_i,
	input  logic [lcs_pkg::COLUMN_BITS-1:0] rd0,
	input  logic [lcs_pkg::COLUMN_BITS-1:0] rd1,
	output lcs_pkg::token_t           tok_o
);
	import lcs_pkg::*;

	logic [CNT_W:0]         pos_end;
	logic                   in_range;
	logic                   sel;
	logic [COLUMN_BITS-1:0] rdata;
	logic                   less;
	logic                   adv;
	token_t                 tok_q;

	// the level above fetched both candidate entries; its decision sits in pos
	assign sel      = |(tok_i.pos & (step << 1));
	assign rdata    = sel ? rd1 : rd0;
	assign pos_end  = {1'b0, tok_i.pos} + {1'b0, step};
	assign in_range = pos_end <= {1'b0, count};
	assign less     = rdata < tok_i.key;
	assign adv      = in_range && less;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_i.valid;
			tok_q.fin   <= tok_i.fin;
			tok_q.key   <= tok_i.key;
			tok_q.pos   <= adv ? CNT_W'(pos_end) : tok_i.pos;
			// last entry found not below the key is the one at the final position
			tok_q.eq    <= (in_range && !less) ? (rdata == tok_i.key) : tok_i.eq;
		end
	end

	assign tok_o = tok_q;

endmodule

>>> rtl/lcs_threshold_update.sv
// lcs_threshold_update: Hunt-Szymanski threshold table with a chain of search cells.
// Depends on lcs_pkg, lcs_cell and lcs_ram.
//
//  channel | signals                                   | role
//  in      | in_valid, in_ready, column, final_item    | one match column per transaction
//  out     | out_valid, out_ready, lcs_length, slot,   | one result per input transaction
//          | action, done_res                          |
//
// An item enters the start register, then walks through NLVL registered cells (11 at 1024
// entries); the write-back from the last cell loads the output register.
// One item is in flight; the next is taken as soon as its result has been loaded.
// Reset empties the table; entries hold no reset value and are read only once written.
// A stalled output holds its result; a new item is taken only when the output register is
// empty or being drained in that cycle.
module lcs_threshold_update (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [lcs_pkg::COL_PORT_W-1:0]    column,
	input  logic                              final_item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [lcs_pkg::CNT_W-1:0]         lcs_length,
	output logic [lcs_pkg::SLOT_W-1:0]        slot,
	output logic [1:0]                        action,
	output logic                              done_res
);
	import lcs_pkg::*;

	token_t                 tok [NLVL+1];
	logic [COLUMN_BITS-1:0] rd0 [NLVL];
	logic [COLUMN_BITS-1:0] rd1 [NLVL];
	logic [NLVL-1:0]        lvl_we;

	token_t             start_q;
	logic               busy_q;
	logic [CNT_W-1:0]   count_q;
	logic               out_valid_q;
	logic [CNT_W-1:0]   len_q;
	logic [SLOT_W-1:0]  slot_q;
	action_t            act_q;
	logic               done_q;

	token_t             tok_wb;
	logic               is_app;
	action_t            act;
	logic               wr_en;
	logic [CNT_W-1:0]   count_nxt;
	logic [SLOT_W-1:0]  slot_nxt;
	logic               accept;

	assign accept   = in_valid && in_ready;
	assign in_ready = !busy_q && (!out_valid_q || out_ready);
	assign tok[NLVL] = start_q;
	assign tok_wb   = tok[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			busy_q  <= 1'b0;
		end else begin
			start_q.valid <= accept;
			if (accept) begin
				start_q.fin <= final_item;
				start_q.eq  <= 1'b0;
				start_q.key <= COLUMN_BITS'(column);
				start_q.pos <= '0;
				busy_q      <= 1'b1;
			end else if (tok_wb.valid) begin
				busy_q <= 1'b0;
			end
		end
	end

	for (genvar b = 0; b < NLVL; b++) begin : g_lvl
		localparam int DEP  = (b == NLVL - 1) ? 1 : (TABLE_DEPTH >> (b + 1));
		localparam int AW   = (DEP > 1) ? $clog2(DEP) : 1;
		localparam int MASK = (1 << (b + 1)) - 1;
		localparam int PAT  = (1 << b) - 1;

		logic [AW-1:0] raddr0;
		logic [AW-1:0] raddr1;
		logic [AW-1:0] waddr;

		if (b == NLVL - 1) begin : g_top
			assign raddr0 = '0;
			assign raddr1 = '0;
		end else begin : g_mid
			// both outcomes of the level above are fetched while it decides
			assign raddr0 = AW'(tok[b+2].pos >> (b + 1));
			assign raddr1 = AW'((tok[b+2].pos >> (b + 1)) + CNT_W'(1));
		end

		// entry index with b trailing ones and a zero above them lives on level b
		assign waddr     = AW'(tok_wb.pos >> (b + 1));
		assign lvl_we[b] = wr_en &&
			(({1'b0, tok_wb.pos} & (CNT_W+1)'(MASK)) == (CNT_W+1)'(PAT));

		lcs_ram #(
			.DEPTH (1 << AW),
			.AW    (AW),
			.DW    (COLUMN_BITS)
		) u_ram (
			.clk    (clk),
			.we     (lvl_we[b]),
			.waddr  (waddr),
			.wdata  (tok_wb.key),
			.raddr0 (raddr0),
			.raddr1 (raddr1),
			.rdata0 (rd0[b]),
			.rdata1 (rd1[b])
		);

		lcs_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (CNT_W'(1) << b),
			.count  (count_q),
			.tok_i  (tok[b+1]),
			.rd0    (rd0[b]),
			.rd1    (rd1[b]),
			.tok_o  (tok[b])
		);
	end

	// write-back decision
	always_comb begin
		is_app    = tok_wb.pos >= count_q;
		count_nxt = count_q;
		slot_nxt  = SLOT_W'(tok_wb.pos);
		if (!is_app) begin
			act = tok_wb.eq ? ACT_KEEP : ACT_REPLACE;
		end else if (count_q < CNT_W'(TABLE_DEPTH)) begin
			act       = ACT_APPEND;
			count_nxt = count_q + CNT_W'(1);
		end else begin
			act      = ACT_DROP;
			slot_nxt = SLOT_W'(TABLE_DEPTH - 1);
		end
		wr_en = tok_wb.valid && (act == ACT_REPLACE || act == ACT_APPEND);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (tok_wb.valid) begin
				count_q     <= tok_wb.fin ? '0 : count_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_wb.valid) begin
			len_q  <= count_nxt;
			slot_q <= slot_nxt;
			act_q  <= act;
			done_q <= tok_wb.fin;
		end
	end

	assign out_valid  = out_valid_q;
	assign lcs_length = len_q;
	assign slot       = slot_q;
	assign action     = act_q;
	assign done_res   = done_q;

endmodule
